// ----- rtl/servo_pwm_button_stepper_with_readout_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the servo PWM stepper
// Clocked assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SERVO_PWM_BUTTON_STEPPER_WITH_READOUT_TOP_ASSERT_SVH
`define SERVO_PWM_BUTTON_STEPPER_WITH_READOUT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define SPBSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SPBSR_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPBSR_ASSERT(lbl, prop, msg)
`define SPBSR_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

// ----- rtl/spbsr_pkg.sv -----
// ----------------------------------------------------------------------------
// spbsr_pkg
// Shared types, register indexes, reset values and display helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package spbsr_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int NUM_DIGITS  = 3;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam int SEL_WIDTH   = $clog2(NUM_DIGITS);
	localparam logic [NUM_DIGITS-1:0] DIGIT_FIRST = NUM_DIGITS'(1 << (NUM_DIGITS - 1));

	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t CFG_PWM_TOP          = 3'd0;
	localparam cfg_index_t CFG_PULSE_MIN        = 3'd1;
	localparam cfg_index_t CFG_PULSE_MAX        = 3'd2;
	localparam cfg_index_t CFG_PULSE_STEP       = 3'd3;
	localparam cfg_index_t CFG_DEGREES_PER_STEP = 3'd4;
	localparam cfg_index_t CFG_DIGIT_HOLD_TICKS = 3'd5;

	localparam logic [15:0] RST_PWM_TOP          = 16'd39999;
	localparam logic [15:0] RST_PULSE_MIN        = 16'd1000;
	localparam logic [15:0] RST_PULSE_MAX        = 16'd5000;
	localparam logic [15:0] RST_PULSE_STEP       = 16'd200;
	localparam logic [7:0]  RST_DEGREES_PER_STEP = 8'd9;
	localparam logic [15:0] RST_DIGIT_HOLD_TICKS = 16'd4000;
	localparam logic [15:0] RST_COMPARE          = 16'd1000;
	localparam logic [1:0]  RST_BUTTONS          = 2'b11;

	typedef struct packed {
		logic up_button_level;
		logic down_button_level;
	} in_item_t;

	typedef struct packed {
		logic                  pwm_out;
		logic [6:0]            segments_n;
		logic [NUM_DIGITS-1:0] digit_enable;
		logic [15:0]           pulse_width;
		logic [7:0]            angle_degrees;
	} out_item_t;

	// Decimal digit of an 8-bit value: select 0 hundreds, 1 tens, else units
	function automatic logic [3:0] digit_of(input logic [7:0] a, input logic [SEL_WIDTH-1:0] sel);
		logic [1:0] hund;
		logic [7:0] rem;
		logic [3:0] tens;
		logic [7:0] units;
		hund = (a >= 8'd200) ? 2'd2 : ((a >= 8'd100) ? 2'd1 : 2'd0);
		rem = a - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
		tens = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (rem >= 8'(10 * k))
				tens = 4'(k);
		end
		units = rem - 8'(tens) * 8'd10;
		case (sel)
			SEL_WIDTH'(0): digit_of = {2'b00, hund};
			SEL_WIDTH'(1): digit_of = tens;
			default:       digit_of = units[3:0];
		endcase
	endfunction

	// Active-low segment pattern, bit0 = a .. bit6 = g
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		case (d)
			4'd0:    seg_of = 7'h40;
			4'd1:    seg_of = 7'h79;
			4'd2:    seg_of = 7'h24;
			4'd3:    seg_of = 7'h30;
			4'd4:    seg_of = 7'h19;
			4'd5:    seg_of = 7'h12;
			4'd6:    seg_of = 7'h02;
			4'd7:    seg_of = 7'h78;
			4'd8:    seg_of = 7'h00;
			4'd9:    seg_of = 7'h18;
			default: seg_of = 7'h7F;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- rtl/spbsr_readout.sv -----
// ----------------------------------------------------------------------------
// spbsr_readout
// Multiplexed three-digit display: digit rotation timer and segment decode.
// ----------------------------------------------------------------------------
`default_nettype none

module spbsr_readout (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [15:0]                      hold_ticks,
	input  logic [7:0]                       angle,
	output logic [6:0]                       segments_n,
	output logic [spbsr_pkg::NUM_DIGITS-1:0] digit_enable
);
	import spbsr_pkg::*;

	logic [15:0]          hold_q;
	logic [SEL_WIDTH-1:0] sel_q;
	logic [SEL_WIDTH-1:0] sel_next;
	logic [15:0]          hold_lim;
	logic [16:0]          hold_inc;
	logic                 roll;

	// a hold of zero behaves as one
	assign hold_lim = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
	assign hold_inc = {1'b0, hold_q} + 17'd1;
	assign roll     = hold_inc >= {1'b0, hold_lim};
	assign sel_next = (sel_q == SEL_WIDTH'(NUM_DIGITS - 1)) ? '0 : sel_q + SEL_WIDTH'(1);

	assign segments_n   = seg_of(digit_of(angle, sel_q));
	assign digit_enable = DIGIT_FIRST >> sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			sel_q  <= '0;
		end else if (step) begin
			if (roll) begin
				hold_q <= '0;
				sel_q  <= sel_next;
			end else begin
				hold_q <= hold_inc[15:0];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/servo_pwm_button_stepper_with_readout_top.sv -----
// ----------------------------------------------------------------------------
// servo_pwm_button_stepper_with_readout_top
// Servo PWM with button-stepped pulse width and a decimal angle readout.
// ----------------------------------------------------------------------------
// Each transaction is one timer tick and yields one result transaction. The
// block takes a tick every clock unless the output stalls; a tick enters an
// input register and its result leaves from a result register. All
// state (PWM counter, compares, angle, display timer) updates in the cycle the
// tick moves from the input register to the result register, in one pass of
// short logic. A stalled output holds the result register and, once the input
// register is full too, drops in_ready. Configuration writes take effect at
// the clock edge on which cfg_we is high.
`default_nettype none

module servo_pwm_button_stepper_with_readout_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  spbsr_pkg::in_item_t     in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output spbsr_pkg::out_item_t    out_item,
	input  logic                    cfg_we,
	input  spbsr_pkg::cfg_index_t   cfg_index,
	input  logic [15:0]             cfg_data
);
	import spbsr_pkg::*;

	`include "servo_pwm_button_stepper_with_readout_top_assert.svh"

	// configuration
	logic [15:0] pwm_top_q, pulse_min_q, pulse_max_q, pulse_step_q, hold_ticks_q;
	logic [7:0]  dps_q;

	// pipeline
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	logic      adv_s1;

	// block state
	logic [COUNT_WIDTH-1:0] count_q;
	logic [15:0]            cmp_active_q;
	logic [15:0]            cmp_pend_q;
	logic [7:0]             angle_q;
	logic [1:0]             btn_before_q;

	logic [1:0]             levels;
	logic                   changed;
	logic                   up_take;
	logic                   dn_take;
	logic [15:0]            pend_up;
	logic [15:0]            pend_dn;
	logic [15:0]            pend_next;
	logic [7:0]             angle_next;
	logic                   pwm;
	logic                   wrap;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [6:0]             segs;
	logic [NUM_DIGITS-1:0]  digits;

	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q    <= RST_PWM_TOP;
			pulse_min_q  <= RST_PULSE_MIN;
			pulse_max_q  <= RST_PULSE_MAX;
			pulse_step_q <= RST_PULSE_STEP;
			dps_q        <= RST_DEGREES_PER_STEP;
			hold_ticks_q <= RST_DIGIT_HOLD_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PWM_TOP:          pwm_top_q    <= cfg_data;
				CFG_PULSE_MIN:        pulse_min_q  <= cfg_data;
				CFG_PULSE_MAX:        pulse_max_q  <= cfg_data;
				CFG_PULSE_STEP:       pulse_step_q <= cfg_data;
				CFG_DEGREES_PER_STEP: dps_q        <= cfg_data[7:0];
				CFG_DIGIT_HOLD_TICKS: hold_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// button handling: up step first, then down step on the updated compare
	always_comb begin
		levels   = {item_s1.down_button_level, item_s1.up_button_level};
		changed  = levels != btn_before_q;
		pend_up  = cmp_pend_q + pulse_step_q;
		pend_dn  = cmp_pend_q - pulse_step_q;
		up_take  = changed && !item_s1.up_button_level && (cmp_pend_q < pulse_max_q);
		dn_take  = changed && !item_s1.down_button_level &&
			(up_take ? (pend_up > pulse_min_q) : (cmp_pend_q > pulse_min_q));
		// both steps cancel out modulo 2^16
		case ({up_take, dn_take})
			2'b10: begin
				pend_next  = pend_up;
				angle_next = angle_q + dps_q;
			end
			2'b01: begin
				pend_next  = pend_dn;
				angle_next = angle_q - dps_q;
			end
			default: begin
				pend_next  = cmp_pend_q;
				angle_next = angle_q;
			end
		endcase
		pwm        = CMP_WIDTH'(count_q) <= CMP_WIDTH'(cmp_active_q);
		wrap       = CMP_WIDTH'(count_q) >= CMP_WIDTH'(pwm_top_q);
		count_next = wrap ? '0 : count_q + COUNT_WIDTH'(1);
	end

	spbsr_readout u_readout (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.hold_ticks   (hold_ticks_q),
		.angle        (angle_next),
		.segments_n   (segs),
		.digit_enable (digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			count_q      <= '0;
			cmp_active_q <= RST_COMPARE;
			cmp_pend_q   <= RST_COMPARE;
			angle_q      <= '0;
			btn_before_q <= RST_BUTTONS;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s1) begin
				valid_s2     <= 1'b1;
				count_q      <= count_next;
				cmp_pend_q   <= pend_next;
				angle_q      <= angle_next;
				btn_before_q <= levels;
				if (wrap)
					cmp_active_q <= pend_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
		if (adv_s1) begin
			res_s2.pwm_out       <= pwm;
			res_s2.segments_n    <= segs;
			res_s2.digit_enable  <= digits;
			res_s2.pulse_width   <= pend_next;
			res_s2.angle_degrees <= angle_next;
		end
	end

	`SPBSR_ASSERT_ALL(a_reset_empty, !arst_n |-> (!valid_s1 && !valid_s2), "pipeline not empty in reset")
	`SPBSR_ASSERT(a_digit_onehot, valid_s2 |-> $onehot(res_s2.digit_enable), "digit enable not one-hot")
	`SPBSR_ASSERT(a_pulse_track, valid_s2 |-> (res_s2.pulse_width == cmp_pend_q), "pulse width lost track of compare")
	`SPBSR_ASSERT(a_angle_track, valid_s2 |-> (res_s2.angle_degrees == angle_q), "angle readout lost track of angle")
	`SPBSR_ASSERT(a_advance, (valid_s1 && (!valid_s2 || out_ready)) |=> valid_s2, "tick did not reach result register")

endmodule

`default_nettype wire
